// ----- design/jkme_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jkme_pkg
// Shared widths, finisher states and controller/datapath command types for
// the jackknife mean and error block.
// ----------------------------------------------------------------------------
package jkme_pkg;

   localparam int SITE_W           = 16;
   localparam int SAMPLE_W         = 32;
   localparam int ERR_W            = 32;
   localparam int FRAC_W           = 16;
   localparam int SQUARE_W         = 47;  // floor(s*s / 2^16) of a 32-bit sample
   localparam int DIGIT_W          = 16;  // quotient bits per divide step
   localparam int ROOT_STEPS       = 32;
   localparam int NUM_BINS_DEFAULT = 64;

   typedef enum logic [3:0] {
      FIN_IDLE,
      FIN_ABS,
      FIN_DIV,
      FIN_MEAN,
      FIN_SQUARE,
      FIN_DIFF,
      FIN_PROD,
      FIN_RINIT,
      FIN_ROOT,
      FIN_DONE
   } fin_state_type;

   typedef struct packed {
      logic load_in;
      logic accum;
      logic close;
      logic abs_sum;
      logic div_step;
      logic mean;
      logic square;
      logic diff;
      logic prod;
      logic root_init;
      logic root_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic last_sample;
   } status_type;

endpackage

// ----- design/jkme_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jkme_datapath
// Input square stage, sum and sum-of-squares accumulators, two divide lanes
// (reciprocal multiply, one 16-bit quotient digit per cycle), mean/variance
// arithmetic, bit-serial square root and the result register.
// ----------------------------------------------------------------------------
module jkme_datapath import jkme_pkg::*; #(
   parameter int NUM_BINS = NUM_BINS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cmd_type                    cmd,
   output status_type                 status,
   input  logic [SITE_W-1:0]          req_site_index,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   output logic [SITE_W-1:0]          rsp_site_out,
   output logic signed [SAMPLE_W-1:0] rsp_mean_value,
   output logic [ERR_W-1:0]           rsp_error_value
);

   localparam int CLOG     = $clog2(NUM_BINS);
   localparam int SUM_W    = SAMPLE_W + CLOG;
   localparam int ACC_W    = SQUARE_W + CLOG;
   localparam int DIGITS   = (ACC_W + DIGIT_W - 1) / DIGIT_W;
   localparam int LANE_W   = DIGITS * DIGIT_W;
   localparam int PART_W   = CLOG + DIGIT_W;
   localparam int RECIP_SH = PART_W + CLOG;
   localparam int RECIP_W  = PART_W + 1;
   localparam int QPROD_W  = PART_W + RECIP_W;
   localparam int MSQR_W   = 2 * SAMPLE_W - FRAC_W;
   localparam int PROD_W   = MSQR_W + CLOG;
   localparam int RAD_W    = 2 * ERR_W;
   localparam int REM_W    = ERR_W + 2;
   localparam logic [CLOG-1:0]    LAST_CNT = CLOG'(NUM_BINS - 1);
   localparam logic [CLOG-1:0]    SCALE    = CLOG'(NUM_BINS - 1);
   localparam logic [PART_W-1:0]  DIVISOR  = PART_W'(NUM_BINS);
   // ceil(2^RECIP_SH / NUM_BINS): exact floor quotient for any partial < 2^PART_W
   localparam logic [RECIP_W-1:0] RECIP    =
      RECIP_W'(((64'd1 << RECIP_SH) + 64'(NUM_BINS) - 64'd1) / 64'(NUM_BINS));

   // input stage
   logic [CLOG-1:0]             cnt_ff, cnt_in;
   logic [SITE_W-1:0]           p1_site_ff;
   logic signed [SAMPLE_W-1:0]  p1_sample_ff;
   logic [SQUARE_W-1:0]         p1_square_ff;
   logic signed [2*SAMPLE_W-1:0] square_full;

   // accumulators
   logic signed [SUM_W-1:0]     acc_sum_ff, acc_sum_in, sum_next;
   logic [ACC_W-1:0]            acc_sq_ff, acc_sq_in, sq_next;

   // finisher
   logic [SITE_W-1:0]           fin_site_ff;
   logic                        neg_ff;
   logic [LANE_W-1:0]           lane_sum_ff, lane_sq_ff;
   logic [CLOG-1:0]             rem_sum_ff, rem_sq_ff;
   logic [PART_W-1:0]           sum_part, sq_part;
   logic [QPROD_W-1:0]          sum_qprod, sq_qprod;
   logic [DIGIT_W-1:0]          sum_digit, sq_digit;
   logic [PART_W-1:0]           sum_back, sq_back;
   logic [SAMPLE_W:0]           mmag_wide;
   logic [SAMPLE_W-1:0]         mmag_ff;
   logic signed [SAMPLE_W-1:0]  mean_ff;
   logic [SQUARE_W-1:0]         msq_ff;
   logic [2*SAMPLE_W-1:0]       mmag_square;
   logic [MSQR_W-1:0]           meansq_ff;
   logic [SQUARE_W-1:0]         diff_ff;
   logic [PROD_W-1:0]           prod_ff;
   logic                        sat_ff;
   logic [RAD_W-1:0]            rad_ff;
   logic [ERR_W-1:0]            root_ff;
   logic [REM_W-1:0]            rrem_ff;
   logic [REM_W+1:0]            root_rem_t, root_trial;
   logic                        root_fits;

   assign status.last_sample = (cnt_ff == LAST_CNT);
   assign cnt_in = status.last_sample ? '0 : cnt_ff + 1'b1;

   assign square_full = req_sample * req_sample;

   assign sum_next = acc_sum_ff + SUM_W'(p1_sample_ff);
   assign sq_next  = acc_sq_ff + ACC_W'(p1_square_ff);

   always_comb begin
      acc_sum_in = acc_sum_ff;
      acc_sq_in  = acc_sq_ff;
      if (cmd.close) begin
         acc_sum_in = '0;
         acc_sq_in  = '0;
      end else if (cmd.accum) begin
         acc_sum_in = sum_next;
         acc_sq_in  = sq_next;
      end
   end

   // partial dividend = remainder so far, then the next 16-bit digit
   assign sum_part  = {rem_sum_ff, lane_sum_ff[LANE_W-1 -: DIGIT_W]};
   assign sq_part   = {rem_sq_ff, lane_sq_ff[LANE_W-1 -: DIGIT_W]};
   assign sum_qprod = QPROD_W'(sum_part) * QPROD_W'(RECIP);
   assign sq_qprod  = QPROD_W'(sq_part) * QPROD_W'(RECIP);
   assign sum_digit = sum_qprod[RECIP_SH +: DIGIT_W];
   assign sq_digit  = sq_qprod[RECIP_SH +: DIGIT_W];
   assign sum_back  = PART_W'(sum_digit) * DIVISOR;
   assign sq_back   = PART_W'(sq_digit) * DIVISOR;

   assign mmag_wide = {1'b0, lane_sum_ff[SAMPLE_W-1:0]}
                      + (SAMPLE_W + 1)'(neg_ff && (rem_sum_ff != '0));
   assign mmag_square = mmag_ff * mmag_ff;

   assign root_rem_t = {rrem_ff, rad_ff[RAD_W-1 -: 2]};
   assign root_trial = {2'b00, root_ff, 2'b01};
   assign root_fits  = (root_rem_t >= root_trial);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         acc_sum_ff <= '0;
         acc_sq_ff  <= '0;
      end else begin
         if (cmd.load_in) begin
            cnt_ff <= cnt_in;
         end
         acc_sum_ff <= acc_sum_in;
         acc_sq_ff  <= acc_sq_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         p1_site_ff   <= req_site_index;
         p1_sample_ff <= req_sample;
         p1_square_ff <= square_full[FRAC_W +: SQUARE_W];
      end
      if (cmd.close) begin
         fin_site_ff <= p1_site_ff;
         neg_ff      <= sum_next[SUM_W-1];
         lane_sum_ff <= LANE_W'(sum_next);
         lane_sq_ff  <= LANE_W'(sq_next);
         rem_sum_ff  <= '0;
         rem_sq_ff   <= '0;
      end
      if (cmd.abs_sum && neg_ff) begin
         lane_sum_ff <= -lane_sum_ff;
      end
      if (cmd.div_step) begin
         lane_sum_ff <= {lane_sum_ff[LANE_W-DIGIT_W-1:0], sum_digit};
         lane_sq_ff  <= {lane_sq_ff[LANE_W-DIGIT_W-1:0], sq_digit};
         rem_sum_ff  <= CLOG'(sum_part - sum_back);
         rem_sq_ff   <= CLOG'(sq_part - sq_back);
      end
      if (cmd.mean) begin
         mmag_ff <= mmag_wide[SAMPLE_W-1:0];
         msq_ff  <= lane_sq_ff[SQUARE_W-1:0];
      end
      if (cmd.square) begin
         meansq_ff <= mmag_square[FRAC_W +: MSQR_W];
         mean_ff   <= neg_ff ? -$signed(mmag_ff) : $signed(mmag_ff);
      end
      if (cmd.diff) begin
         diff_ff <= (MSQR_W'(msq_ff) > meansq_ff) ?
                    SQUARE_W'(MSQR_W'(msq_ff) - meansq_ff) : '0;
      end
      if (cmd.prod) begin
         prod_ff <= PROD_W'(diff_ff) * PROD_W'(SCALE);
      end
      if (cmd.root_init) begin
         sat_ff  <= |prod_ff[PROD_W-1:MSQR_W];
         rad_ff  <= {prod_ff[MSQR_W-1:0], FRAC_W'(0)};
         root_ff <= '0;
         rrem_ff <= '0;
      end
      if (cmd.root_step) begin
         rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
         root_ff <= {root_ff[ERR_W-2:0], root_fits};
         rrem_ff <= root_fits ? REM_W'(root_rem_t - root_trial) : root_rem_t[REM_W-1:0];
      end
      if (cmd.load_out) begin
         rsp_site_out    <= fin_site_ff;
         rsp_mean_value  <= mean_ff;
         rsp_error_value <= sat_ff ? '1 : root_ff;
      end
   end

endmodule

// ----- design/jkme_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jkme_ctrl
// Handshake control, input stage tracking and the finisher sequencer
// (divide, mean, variance, square root, result load).
// ----------------------------------------------------------------------------
module jkme_ctrl import jkme_pkg::*; #(
   parameter int NUM_BINS = NUM_BINS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  status_type status,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output cmd_type    cmd
);

   localparam int DIV_STEPS = (SQUARE_W + $clog2(NUM_BINS) + DIGIT_W - 1) / DIGIT_W;
   localparam int STEP_W    = $clog2(ROOT_STEPS);
   localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(DIV_STEPS - 1);
   localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(ROOT_STEPS - 1);

   fin_state_type     state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              p1_valid_ff, p1_valid_in;
   logic              p1_last_ff, p1_last_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept;

   assign req_ready = !(status.last_sample && (state_ff != FIN_IDLE));
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.load_in  = accept;
      cmd.accum    = p1_valid_ff;
      cmd.close    = p1_valid_ff && p1_last_ff;
      state_in     = state_ff;
      step_in      = step_ff;
      p1_valid_in  = accept;
      p1_last_in   = accept ? status.last_sample : p1_last_ff;
      case (state_ff)
         FIN_IDLE: begin
            if (cmd.close) begin
               state_in = FIN_ABS;
            end
         end
         FIN_ABS: begin
            cmd.abs_sum = 1'b1;
            step_in     = '0;
            state_in    = FIN_DIV;
         end
         FIN_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == DIV_LAST) begin
               state_in = FIN_MEAN;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         FIN_MEAN: begin
            cmd.mean = 1'b1;
            state_in = FIN_SQUARE;
         end
         FIN_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = FIN_DIFF;
         end
         FIN_DIFF: begin
            cmd.diff = 1'b1;
            state_in = FIN_PROD;
         end
         FIN_PROD: begin
            cmd.prod = 1'b1;
            state_in = FIN_RINIT;
         end
         FIN_RINIT: begin
            cmd.root_init = 1'b1;
            step_in       = '0;
            state_in      = FIN_ROOT;
         end
         FIN_ROOT: begin
            cmd.root_step = 1'b1;
            if (step_ff == ROOT_LAST) begin
               state_in = FIN_DONE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         FIN_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in     = FIN_IDLE;
            end
         end
         default: begin
            state_in = FIN_IDLE;
         end
      endcase
      rsp_valid_in = cmd.load_out || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FIN_IDLE;
         step_ff      <= '0;
         p1_valid_ff  <= 1'b0;
         p1_last_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         p1_valid_ff  <= p1_valid_in;
         p1_last_ff   <= p1_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // a group may only close into an idle finisher
   a_close_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.close |-> (state_ff == FIN_IDLE))
      else $error("group closed while finisher busy");

   a_close_start: assert property (@(posedge clock) disable iff (reset)
      cmd.close |=> (state_ff == FIN_ABS))
      else $error("finisher did not start after group close");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten before transaction");

   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FIN_DIV) |-> (step_ff <= DIV_LAST))
      else $error("divider step count out of range");

endmodule

// ----- design/jackknife_mean_error.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jackknife_mean_error
// Mean and jackknife error of groups of NUM_BINS signed Q16.16 bin samples.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while req_ready is high. Every NUM_BINS-th
// sample closes a group; its sum and sum of squares pass to a finisher: one
// sign step, D divide steps by NUM_BINS (reciprocal multiply, one 16-bit
// quotient digit per cycle, D = ceil((47 + log2(NUM_BINS)) / 16), which is 4
// for NUM_BINS from 3 to 2^17), five arithmetic steps, a 32-step bit-serial
// square root and a result load. The next group accumulates meanwhile; its
// closing sample is held off (req_ready low) until the finisher is idle
// again, and a finished result may wait on rsp_ready.
// ----------------------------------------------------------------------------
module jackknife_mean_error import jkme_pkg::*; #(
   parameter int NUM_BINS = NUM_BINS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [SITE_W-1:0]          req_site_index,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [SITE_W-1:0]          rsp_site_out,
   output logic signed [SAMPLE_W-1:0] rsp_mean_value,
   output logic [ERR_W-1:0]           rsp_error_value
);

   cmd_type    cmd;
   status_type status;

   jkme_ctrl #(
      .NUM_BINS (NUM_BINS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   jkme_datapath #(
      .NUM_BINS (NUM_BINS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_site_index  (req_site_index),
      .req_sample      (req_sample),
      .rsp_site_out    (rsp_site_out),
      .rsp_mean_value  (rsp_mean_value),
      .rsp_error_value (rsp_error_value)
   );

endmodule

// ----- bench/jkme_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jkme_checker
// Scoreboard for the jackknife mean and error block.
// ----------------------------------------------------------------------------
// Watches both channels at the rising clock edge. Every accepted sample is
// folded into a local copy of the group sums; each closing sample queues the
// site, mean and error the block owes for that group. Accepted results are
// compared field by field against the oldest queued group. The failure count,
// the number of groups still owed and the number of results checked go to
// the bench top.
// ----------------------------------------------------------------------------
module jkme_checker import jkme_pkg::*; #(
   parameter int NUM_BINS = NUM_BINS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [SITE_W-1:0]          req_site_index,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic [SITE_W-1:0]          rsp_site_out,
   input  logic signed [SAMPLE_W-1:0] rsp_mean_value,
   input  logic [ERR_W-1:0]           rsp_error_value,
   output int                         fail_count,
   output int                         open_results,
   output int                         results_checked
);

   typedef struct packed {
      logic [SITE_W-1:0]          site;
      logic signed [SAMPLE_W-1:0] mean;
      logic [ERR_W-1:0]           error;
   } group_stats_type;

   group_stats_type owed_groups[$];

   longint      group_sum;
   logic [63:0] group_square_sum;
   int          group_count;

   initial begin
      fail_count      = 0;
      open_results    = 0;
      results_checked = 0;
   end

   task automatic report(input string msg);
      begin
         $display("ERROR @%0t: %s", $realtime, msg);
         fail_count++;
      end
   endtask

   // floor(sqrt(v)), one result bit per pass from the top down
   function automatic logic [ERR_W-1:0] floor_root(input logic [63:0] v);
      logic [63:0] root;
      logic [63:0] trial;
      begin
         root = 64'd0;
         for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
               root = trial;
         end
         return root[ERR_W-1:0];
      end
   endfunction

   function automatic group_stats_type close_group(input logic [SITE_W-1:0] site,
                                                   input longint sum,
                                                   input logic [63:0] square_sum);
      group_stats_type stats;
      longint          mean;
      logic [63:0]     mean_mag;
      logic [63:0]     mean_sq;
      logic [63:0]     mean_of_sq;
      logic [63:0]     spread;
      logic [63:0]     scaled;
      begin
         if (sum >= 0)
            mean = sum / longint'(NUM_BINS);
         else
            mean = -((-sum + longint'(NUM_BINS) - 1) / longint'(NUM_BINS));
         mean_mag   = (mean < 0) ? 64'(-mean) : 64'(mean);
         mean_sq    = (mean_mag * mean_mag) >> FRAC_W;
         mean_of_sq = square_sum / 64'(NUM_BINS);
         spread     = (mean_of_sq > mean_sq) ? mean_of_sq - mean_sq : 64'd0;
         scaled     = 64'(NUM_BINS - 1) * spread;
         stats.site = site;
         stats.mean = mean[SAMPLE_W-1:0];
         if (scaled >= (64'd1 << 48))
            stats.error = '1;
         else
            stats.error = floor_root(scaled << FRAC_W);
         return stats;
      end
   endfunction

   always @(posedge clock) begin
      longint          value;
      logic [63:0]     mag;
      group_stats_type want;
      if (reset) begin
         group_sum        = 0;
         group_square_sum = 64'd0;
         group_count      = 0;
         owed_groups.delete();
      end else begin
         if (req_valid && req_ready) begin
            value            = longint'(req_sample);
            mag              = (value < 0) ? 64'(-value) : 64'(value);
            group_sum        = group_sum + value;
            group_square_sum = group_square_sum + ((mag * mag) >> FRAC_W);
            group_count++;
            if (group_count == NUM_BINS) begin
               owed_groups.push_back(close_group(req_site_index, group_sum,
                                                 group_square_sum));
               group_sum        = 0;
               group_square_sum = 64'd0;
               group_count      = 0;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (owed_groups.size() == 0) begin
               report($sformatf("result with none owed: site %h mean %h error %h",
                                rsp_site_out, rsp_mean_value, rsp_error_value));
            end else begin
               want = owed_groups.pop_front();
               results_checked++;
               if (rsp_site_out !== want.site)
                  report($sformatf("site_out got %h expected %h",
                                   rsp_site_out, want.site));
               if (rsp_mean_value !== want.mean)
                  report($sformatf("mean_value got %h expected %h",
                                   rsp_mean_value, want.mean));
               if (rsp_error_value !== want.error)
                  report($sformatf("error_value got %h expected %h",
                                   rsp_error_value, want.error));
            end
         end
      end
      open_results = owed_groups.size();
   end

endmodule

// ----- bench/jackknife_mean_error_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jackknife_mean_error_tb
// Bench top for the jackknife mean and error block.
// ----------------------------------------------------------------------------
// Drives whole groups of bin samples: first patterned groups (extreme values,
// floor of a negative mean, saturated error, negative variance from
// truncation, mixed sites), then random groups of several shapes. The sender
// runs in random bursts, the receiver stalls on its own pattern. Checking is
// done by jkme_checker; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module jackknife_mean_error_tb;
   import jkme_pkg::*;

   localparam int BINS           = NUM_BINS_DEFAULT;
   localparam int RANDOM_GROUPS  = 21;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 300;

   logic                       clock           = 1'b0;
   logic                       reset           = 1'b1;
   logic                       req_valid       = 1'b0;
   logic                       req_ready;
   logic [SITE_W-1:0]          req_site_index  = '0;
   logic signed [SAMPLE_W-1:0] req_sample      = '0;
   logic                       rsp_valid;
   logic                       rsp_ready       = 1'b0;
   logic [SITE_W-1:0]          rsp_site_out;
   logic signed [SAMPLE_W-1:0] rsp_mean_value;
   logic [ERR_W-1:0]           rsp_error_value;

   int fail_count;
   int open_results;
   int results_checked;

   int samples_sent  = 0;
   int groups_sent   = 0;
   int burst_left    = 0;
   int idle_cycles   = 0;
   int stall_left    = 0;
   int steady_left   = 0;

   always #5 clock = ~clock;

   jackknife_mean_error #(
      .NUM_BINS(BINS)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_site_index  (req_site_index),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_site_out    (rsp_site_out),
      .rsp_mean_value  (rsp_mean_value),
      .rsp_error_value (rsp_error_value)
   );

   jkme_checker #(
      .NUM_BINS(BINS)
   ) checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_site_index  (req_site_index),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_site_out    (rsp_site_out),
      .rsp_mean_value  (rsp_mean_value),
      .rsp_error_value (rsp_error_value),
      .fail_count      (fail_count),
      .open_results    (open_results),
      .results_checked (results_checked)
   );

   // receiver: short and long stalls, with stretches of steady ready
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
         if (steady_left > 0) begin
            steady_left--;
         end else if ($urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(0, 1) ? $urandom_range(1, 3) : $urandom_range(1, 40);
            if ($urandom_range(0, 7) == 0)
               steady_left = $urandom_range(100, 600);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles, %0d results owed",
                  WATCHDOG_LIMIT, open_results);
         $display("FAIL jackknife_mean_error");
         $finish;
      end
   end

   task automatic send_sample(input logic [SITE_W-1:0] site,
                              input logic [SAMPLE_W-1:0] value);
      int gap;
      begin
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            if (gap > 0) begin
               @(negedge clock);
               req_valid <= 1'b0;
               repeat (gap - 1) @(negedge clock);
            end
            burst_left = $urandom_range(1, 120);
         end
         burst_left--;
         @(negedge clock);
         req_valid      <= 1'b1;
         req_site_index <= site;
         req_sample     <= value;
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         samples_sent++;
      end
   endtask

   initial begin
      logic [SITE_W-1:0]   site;
      logic [SAMPLE_W-1:0] value;
      logic [SAMPLE_W-1:0] center;
      int unsigned         spread;
      int                  shape;
      bit                  mixed_sites;

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // all at the positive extreme: zero variance, largest mean
      for (int i = 0; i < BINS; i++)
         send_sample(16'hFFFF, 32'h7FFF_FFFF);
      groups_sent++;
      // all at the negative extreme
      for (int i = 0; i < BINS; i++)
         send_sample(16'h0000, 32'h8000_0000);
      groups_sent++;
      // alternating extremes: error saturates, mean floors to -1
      for (int i = 0; i < BINS; i++)
         send_sample(16'h5A5A, i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF);
      groups_sent++;
      // truncated squares push the variance below zero
      for (int i = 0; i < BINS; i++)
         send_sample(16'hA5A5, i[0] ? 32'd257 : 32'd255);
      groups_sent++;
      // single negative lsb: floor of a negative mean
      for (int i = 0; i < BINS; i++)
         send_sample(16'h0001, (i == 3) ? 32'hFFFF_FFFF : 32'h0000_0000);
      groups_sent++;
      // mixed sites within one group, last site decides
      for (int i = 0; i < BINS; i++)
         send_sample(i[0] ? 16'hFFFF : 16'h0000, 32'(i) << 20);
      groups_sent++;
      for (int i = 0; i < BINS; i++)
         send_sample(16'($urandom), (i == BINS - 1) ? 32'h0 : $urandom);
      groups_sent++;

      for (int g = 0; g < RANDOM_GROUPS; g++) begin
         shape       = $urandom_range(0, 4);
         mixed_sites = ($urandom_range(0, 4) == 0);
         site        = 16'($urandom);
         center      = $urandom;
         spread      = 32'd1 << $urandom_range(0, 24);
         for (int i = 0; i < BINS; i++) begin
            case (shape)
               0: value = $urandom;
               1: value = center + ($urandom % (2 * spread + 1)) - spread;
               2: value = $urandom_range(0, 2048) - 1024;
               3: begin
                  case ($urandom_range(0, 4))
                     0: value = 32'h7FFF_FFFF;
                     1: value = 32'h8000_0000;
                     2: value = 32'h0000_0000;
                     3: value = 32'hFFFF_FFFF;
                     default: value = 32'h0000_0001;
                  endcase
               end
               default: value = center;
            endcase
            send_sample(mixed_sites ? 16'($urandom) : site, value);
         end
         groups_sent++;
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (open_results != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Covered %0d samples in %0d groups of %0d bins, %0d results checked.",
               samples_sent, groups_sent, BINS, results_checked);
      if (fail_count == 0 && open_results == 0) begin
         $display("PASS jackknife_mean_error");
      end else begin
         $display("%0d mismatches, %0d results owed", fail_count, open_results);
         $display("FAIL jackknife_mean_error");
      end
      $finish;
   end

endmodule
